// ----- src/itr_pkg.sv -----
// shared types, symbol codes and the microcode table for the roman numeral converter
package itr_pkg;

  // ascii codes of the numeral characters
  localparam int SYM_W = 7;
  localparam logic [SYM_W-1:0] SYM_I = 7'h49;
  localparam logic [SYM_W-1:0] SYM_V = 7'h56;
  localparam logic [SYM_W-1:0] SYM_X = 7'h58;
  localparam logic [SYM_W-1:0] SYM_L = 7'h4C;
  localparam logic [SYM_W-1:0] SYM_C = 7'h43;
  localparam logic [SYM_W-1:0] SYM_D = 7'h44;
  localparam logic [SYM_W-1:0] SYM_M = 7'h4D;

  localparam int VAL_W     = 12;
  localparam int NUM_STEPS = 19;
  localparam int PC_W      = $clog2(NUM_STEPS + 1);

  // step operations
  typedef enum logic [1:0] {
    OP_REPEAT,  // emit and subtract while the remainder covers the weight
    OP_PAIR,    // first char of a subtractive pair, skip the pair if not covered
    OP_SECOND,  // second char of a pair, subtract the pair weight
    OP_STOP     // end of program
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] k;
    logic [SYM_W-1:0] sym;
  } ctrl_word_t;

  // datapath control and status
  typedef struct packed {
    logic             load;
    logic [VAL_W-1:0] load_value;
    logic             sub;
    logic [VAL_W-1:0] k;
  } dp_ctrl_t;

  typedef struct packed {
    logic ge;
    logic zero_after;
  } dp_stat_t;

  // microcode rom, greedy walk over the numeral weights
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_W'(0):  w = '{op: OP_REPEAT, k: VAL_W'(1000), sym: SYM_M};
      PC_W'(1):  w = '{op: OP_PAIR,   k: VAL_W'(900),  sym: SYM_C};
      PC_W'(2):  w = '{op: OP_SECOND, k: VAL_W'(900),  sym: SYM_M};
      PC_W'(3):  w = '{op: OP_REPEAT, k: VAL_W'(500),  sym: SYM_D};
      PC_W'(4):  w = '{op: OP_PAIR,   k: VAL_W'(400),  sym: SYM_C};
      PC_W'(5):  w = '{op: OP_SECOND, k: VAL_W'(400),  sym: SYM_D};
      PC_W'(6):  w = '{op: OP_REPEAT, k: VAL_W'(100),  sym: SYM_C};
      PC_W'(7):  w = '{op: OP_PAIR,   k: VAL_W'(90),   sym: SYM_X};
      PC_W'(8):  w = '{op: OP_SECOND, k: VAL_W'(90),   sym: SYM_C};
      PC_W'(9):  w = '{op: OP_REPEAT, k: VAL_W'(50),   sym: SYM_L};
      PC_W'(10): w = '{op: OP_PAIR,   k: VAL_W'(40),   sym: SYM_X};
      PC_W'(11): w = '{op: OP_SECOND, k: VAL_W'(40),   sym: SYM_L};
      PC_W'(12): w = '{op: OP_REPEAT, k: VAL_W'(10),   sym: SYM_X};
      PC_W'(13): w = '{op: OP_PAIR,   k: VAL_W'(9),    sym: SYM_I};
      PC_W'(14): w = '{op: OP_SECOND, k: VAL_W'(9),    sym: SYM_X};
      PC_W'(15): w = '{op: OP_REPEAT, k: VAL_W'(5),    sym: SYM_V};
      PC_W'(16): w = '{op: OP_PAIR,   k: VAL_W'(4),    sym: SYM_I};
      PC_W'(17): w = '{op: OP_SECOND, k: VAL_W'(4),    sym: SYM_V};
      PC_W'(18): w = '{op: OP_REPEAT, k: VAL_W'(1),    sym: SYM_I};
      default:   w = '{op: OP_STOP,   k: '0,           sym: SYM_I};
    endcase
    return w;
  endfunction

endpackage

// ----- src/itr_datapath.sv -----
// remainder register with compare and subtract against the step weight
module itr_datapath
  import itr_pkg::*;
(
  input  logic     clk,
  input  dp_ctrl_t ctrl,
  output dp_stat_t stat
);

  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] diff;

  // compare and subtract
  assign diff            = rem - ctrl.k;
  assign stat.ge         = (rem >= ctrl.k);
  assign stat.zero_after = (diff == '0);

  // remainder update
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= ctrl.load_value;
    end else if (ctrl.sub) begin
      rem <= diff;
    end
  end

endmodule

// ----- src/integer_to_roman_numeral_core.sv -----
// Integer to roman numeral converter, top level.
//
// Input channel s_*: one item carries a 12-bit binary value in s_tdata[11:0].
// Output channel m_*: one item per numeral character, ascii code in
// m_tdata[6:0], m_tlast high on the final character of the numeral.
// A value of zero is taken and produces no output items.
//
// A microcode sequencer walks a 19-step table of weights (1000, 900 ... 1).
// Each cycle it tests one weight against the remainder: a match emits one
// character into the output register once that register is free, a miss
// moves to the next step. An item is therefore loaded, then needs one test
// per character and one per missed step (3888: 15 characters, 12 missed
// steps), all on the single compare-subtract unit.
// For values of 1000 and up the first tested step already emits the first
// character; smaller values first pass over their missed steps. One item
// is converted at a time; s_tready rises again as soon as
// the last character sits in the output register, so the next item can be
// taken while that character still waits.
// A stall on m_tready holds the output register and freezes the sequencer
// at the next emitting step. Reset (rst, synchronous) empties the output
// register and returns the sequencer to idle.
module integer_to_roman_numeral_core
  import itr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [11:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [6:0] symbol
  output logic        m_tlast   // last
);

  logic [PC_W-1:0]  pc, pc_next;
  logic             busy, busy_next;
  ctrl_word_t       word;
  dp_ctrl_t         dp_ctrl;
  dp_stat_t         dp_stat;
  logic             emit_ok;
  logic             load_out;
  logic [SYM_W-1:0] out_sym;
  logic             out_last;
  logic             accept;

  itr_datapath u_datapath (
    .clk  (clk),
    .ctrl (dp_ctrl),
    .stat (dp_stat)
  );

  assign word     = ucode(pc);
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign emit_ok  = !m_tvalid || m_tready;

  // sequencer next state and datapath control
  always_comb begin
    pc_next            = pc;
    busy_next          = busy;
    load_out           = 1'b0;
    out_sym            = word.sym;
    out_last           = 1'b0;
    dp_ctrl.load       = 1'b0;
    dp_ctrl.load_value = s_tdata[VAL_W-1:0];
    dp_ctrl.sub        = 1'b0;
    dp_ctrl.k          = word.k;
    if (busy) begin
      unique case (word.op)
        OP_REPEAT: begin
          if (dp_stat.ge) begin
            if (emit_ok) begin
              load_out    = 1'b1;
              out_last    = dp_stat.zero_after;
              dp_ctrl.sub = 1'b1;
              busy_next   = !dp_stat.zero_after;
            end
          end else begin
            pc_next = pc + PC_W'(1);
          end
        end
        OP_PAIR: begin
          if (dp_stat.ge) begin
            if (emit_ok) begin
              load_out = 1'b1;
              pc_next  = pc + PC_W'(1);
            end
          end else begin
            pc_next = pc + PC_W'(2);
          end
        end
        OP_SECOND: begin
          if (emit_ok) begin
            load_out    = 1'b1;
            out_last    = dp_stat.zero_after;
            dp_ctrl.sub = 1'b1;
            busy_next   = !dp_stat.zero_after;
            pc_next     = pc + PC_W'(1);
          end
        end
        OP_STOP: begin
          busy_next = 1'b0;
        end
      endcase
    end else if (accept) begin
      dp_ctrl.load = 1'b1;
      pc_next      = '0;
      busy_next    = (s_tdata[VAL_W-1:0] != '0);
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  // output register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register, payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, out_sym};
      m_tlast <= out_last;
    end
  end

  // sequencer never runs past the table while converting
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc < PC_W'(NUM_STEPS)))
    else $error("sequencer step out of range");

  // a nonzero value starts a conversion
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tdata[VAL_W-1:0] != '0)) |=> busy)
    else $error("conversion did not start");

  // the end of a conversion leaves the final character in the output register
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (!busy && $past(busy) && !$past(rst)) |-> (m_tvalid && m_tlast))
    else $error("conversion ended without a final character");

  // only numeral letters reach the output
  a_symbol: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] == SYM_I || m_tdata[6:0] == SYM_V ||
                  m_tdata[6:0] == SYM_X || m_tdata[6:0] == SYM_L ||
                  m_tdata[6:0] == SYM_C || m_tdata[6:0] == SYM_D ||
                  m_tdata[6:0] == SYM_M))
    else $error("output symbol is not a numeral letter");

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the integer to roman numeral converter
module tb_top;
  import itr_pkg::*;

  localparam int HALF_HI     = 6;
  localparam int HALF_LO     = 6;
  localparam int RESET_LEN   = 7;
  localparam int RAND_ITEMS  = 156;
  localparam int MAX_WAIT    = 19;
  localparam int DRAIN_LEN   = 60;
  localparam int CYCLE_LIMIT = 400000;

  // expected character stream and the checks against it
  class numeral_board;
    logic [SYM_W-1:0] spelled[$];
    logic [SYM_W-1:0] want_sym[$];
    logic             want_last[$];
    int               fails;
    int               chars_ok;
    int               numerals;
    int               empty_numerals;
    int               oversize;

    function new();
      fails          = 0;
      chars_ok       = 0;
      numerals       = 0;
      empty_numerals = 0;
      oversize       = 0;
    endfunction

    task report(string what);
      $display("  mismatch: %s", what);
      fails++;
    endtask

    function int pending();
      return want_sym.size();
    endfunction

    // one decimal digit in the one/five/ten symbols of its place
    function void spell_digit(int d, logic [SYM_W-1:0] one, logic [SYM_W-1:0] five,
                              logic [SYM_W-1:0] ten);
      if (d == 9) begin
        spelled.push_back(one);
        spelled.push_back(ten);
      end else if (d >= 5) begin
        spelled.push_back(five);
        for (int k = 5; k < d; k++) spelled.push_back(one);
      end else if (d == 4) begin
        spelled.push_back(one);
        spelled.push_back(five);
      end else begin
        for (int k = 0; k < d; k++) spelled.push_back(one);
      end
    endfunction

    // accepted value: queue the characters of its numeral
    function void note_value(logic [VAL_W-1:0] v);
      int n;
      n = int'(v);
      spelled.delete();
      for (int k = 0; k < n / 1000; k++) spelled.push_back(SYM_M);
      spell_digit((n / 100) % 10, SYM_C, SYM_D, SYM_M);
      spell_digit((n / 10) % 10, SYM_X, SYM_L, SYM_C);
      spell_digit(n % 10, SYM_I, SYM_V, SYM_X);
      foreach (spelled[i]) begin
        want_sym.push_back(spelled[i]);
        want_last.push_back(i == spelled.size() - 1);
      end
      numerals++;
      if (n == 0) empty_numerals++;
      if (n > 3999) oversize++;
    endfunction

    // accepted character against the oldest expectation
    task check_char(logic [7:0] data, logic last);
      logic [SYM_W-1:0] sym;
      logic             fin;
      if (want_sym.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last=%0b", data, last));
      end else begin
        sym = want_sym.pop_front();
        fin = want_last.pop_front();
        if (data !== {1'b0, sym})
          report($sformatf("character 0x%02h, wanted '%c'", data, sym));
        else if (last !== fin)
          report($sformatf("last flag %b on '%c', wanted %b", last, sym, fin));
        else
          chars_ok++;
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  numeral_board board = new();
  int           cycles = 0;
  bit           in_burst = 1'b0;
  bit           out_burst = 1'b0;

  integer_to_roman_numeral_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #HALF_HI clk = 1'b1;
    #HALF_LO clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles,
               board.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // offer one value, with a random lead-in gap
  task send_value(logic [VAL_W-1:0] v);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, v};
    do @(posedge clk); while (!s_tready);
    board.note_value(v);
  endtask

  // random value, mostly legal numerals with some zero and oversize values
  function logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)       return '0;
    else if (roll < 15) return VAL_W'($urandom_range(4000, 4095));
    else if (roll < 35) return VAL_W'($urandom_range(1, 99));
    else if (roll < 45) return VAL_W'(3000 + 100 * $urandom_range(7, 8) + 10 * $urandom_range(7, 8)
                                      + $urandom_range(7, 8));
    else                return VAL_W'($urandom_range(1, 3999));
  endfunction

  // result side: random stalls ahead of each character outside of bursts
  initial begin
    int gap;
    int seen;
    seen = 0;
    forever begin
      if (seen % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
      gap = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      board.check_char(m_tdata, m_tlast);
      seen++;
    end
  end

  // stimulus and end of run
  initial begin
    logic [VAL_W-1:0] directed[$];
    directed = '{0, 1, 4, 5, 6, 8, 9, 10, 40, 50, 90, 100, 400, 500, 900, 1000,
                 1994, 2048, 2444, 3499, 3888, 3999, 4000, 4095};

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // digit forms, range ends and values beyond 3999
    foreach (directed[i]) send_value(directed[i]);

    // random values, with stretches of back-to-back items
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 30 == 0) in_burst = ($urandom_range(0, 2) == 0);
      send_value(pick_value());
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    $display("converted %0d values (%0d zero, %0d above 3999), %0d characters matched",
             board.numerals, board.empty_numerals, board.oversize, board.chars_ok);
    $display("%0d mismatches, %0d cycles", board.fails, cycles);
    if (board.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
